// File: rtl/bap_pkg.sv
`timescale 1ns / 1ps

package bap_pkg;

	// Frame and block limits
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_BLOCK    = 64;
	localparam int HEIGHT_LIMIT = 1024;

	// Derived widths
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(HEIGHT_LIMIT);
	localparam int BLK_W = $clog2(MAX_BLOCK);
	localparam int PIX_W = 8;
	localparam int SUM_W = PIX_W + 2 * BLK_W;
	localparam int CNT_W = 2 * BLK_W + 1;

	// Quantizer: sum >= 128 * count
	localparam int THR_SHIFT = 7;
	localparam logic [PIX_W-1:0] QUANT_HIGH = 8'd192;
	localparam logic [PIX_W-1:0] QUANT_LOW  = 8'd64;

	// Configuration port
	localparam int IDX_W    = 2;
	localparam int CFG_W    = 11;
	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 11;
	localparam int SIDE_W   = 7;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 11'd480;
	localparam logic [SIDE_W-1:0]   SIDE_RST   = 7'd8;

	// Output queue depth
	localparam int OUT_DEPTH = 3;
	localparam int LVL_W     = $clog2(OUT_DEPTH + 1);
	localparam int PTR_W     = $clog2(OUT_DEPTH);

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SIDE   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
	} sums_t;

	// Per-pixel control from the raster scanner to the accumulator
	typedef struct packed {
		logic [COL_W-1:0] addr;
		logic             first;
		logic             block_end;
		logic             frame_done;
		logic [COL_W-1:0] block_x;
		logic [ROW_W-1:0] block_y;
		logic [CNT_W-1:0] count;
	} scan_t;

	typedef struct packed {
		logic [COL_W-1:0] block_x;
		logic [ROW_W-1:0] block_y;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             frame_done;
	} result_t;

endpackage

// File: rtl/bap_if.sv
`timescale 1ns / 1ps

interface bap_pix_if import bap_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

interface bap_blk_if import bap_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] block_x;
	logic [ROW_W-1:0] block_y;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;
	logic             frame_done;

	modport source (output valid, output block_x, output block_y, output red_out,
		output green_out, output blue_out, output frame_done, input ready);
	modport sink (input valid, input block_x, input block_y, input red_out,
		input green_out, input blue_out, input frame_done, output ready);
endinterface

interface bap_cfg_if import bap_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/bap_ram.sv
`timescale 1ns / 1ps

module bap_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 60
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, old data on a same-edge collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/bap_scan.sv
`timescale 1ns / 1ps

module bap_scan import bap_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bap_cfg_if.sink   cfg,
	input  logic      accept,
	output scan_t     ctl
);

	localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(HEIGHT_LIMIT);
	localparam logic [SIDE_W-1:0]   SIDE_MAX   = SIDE_W'(MAX_BLOCK);

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [SIDE_W-1:0]   side_q;
	logic [COL_W-1:0]    pixel_col_q;
	logic [ROW_W-1:0]    pixel_row_q;
	logic [BLK_W-1:0]    col_in_blk_q;
	logic [BLK_W-1:0]    row_in_blk_q;
	logic [COL_W-1:0]    blk_col_q;
	logic [ROW_W-1:0]    blk_row_q;

	logic                last_col;
	logic                last_row;
	logic                col_wrap;
	logic                row_wrap;
	logic [SIDE_W-1:0]   col_cnt;
	logic [SIDE_W-1:0]   row_cnt;
	logic [2*SIDE_W-1:0] area;
	logic                cfg_wr;

	// 0 acts as 1, anything above the limit as the limit
	function automatic logic [CFG_W-1:0] clamp(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// Position decode for the next pixel
	assign col_cnt  = SIDE_W'(col_in_blk_q) + SIDE_W'(1);
	assign row_cnt  = SIDE_W'(row_in_blk_q) + SIDE_W'(1);
	assign last_col = (WIDTH_W'(pixel_col_q) + WIDTH_W'(1)) >= width_q;
	assign last_row = (HEIGHT_W'(pixel_row_q) + HEIGHT_W'(1)) >= height_q;
	assign col_wrap = col_cnt >= side_q;
	assign row_wrap = row_cnt >= side_q;
	assign area     = col_cnt * row_cnt;

	always_comb begin
		ctl.addr       = blk_col_q;
		ctl.first      = (col_in_blk_q == '0) && (row_in_blk_q == '0);
		ctl.block_end  = (last_col || col_wrap) && (last_row || row_wrap);
		ctl.frame_done = last_col && last_row;
		ctl.block_x    = blk_col_q;
		ctl.block_y    = blk_row_q;
		ctl.count      = area[CNT_W-1:0];
	end

	// Registers and raster counters; any valid register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= WIDTH_RST;
			height_q     <= HEIGHT_RST;
			side_q       <= SIDE_RST;
			pixel_col_q  <= '0;
			pixel_row_q  <= '0;
			col_in_blk_q <= '0;
			row_in_blk_q <= '0;
			blk_col_q    <= '0;
			blk_row_q    <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(cfg.index))
				REG_WIDTH: begin
					width_q <= WIDTH_W'(clamp(cfg.data, CFG_W'(WIDTH_MAX)));
				end
				REG_HEIGHT: begin
					height_q <= HEIGHT_W'(clamp(cfg.data, CFG_W'(HEIGHT_MAX)));
				end
				REG_SIDE: begin
					side_q <= SIDE_W'(clamp(CFG_W'(cfg.data[SIDE_W-1:0]),
						CFG_W'(SIDE_MAX)));
				end
				default: begin
				end
			endcase
			if (cfg.index == REG_WIDTH || cfg.index == REG_HEIGHT ||
				cfg.index == REG_SIDE) begin
				pixel_col_q  <= '0;
				pixel_row_q  <= '0;
				col_in_blk_q <= '0;
				row_in_blk_q <= '0;
				blk_col_q    <= '0;
				blk_row_q    <= '0;
			end
		end else if (accept) begin
			if (last_col) begin
				pixel_col_q  <= '0;
				col_in_blk_q <= '0;
				blk_col_q    <= '0;
				if (last_row) begin
					pixel_row_q  <= '0;
					row_in_blk_q <= '0;
					blk_row_q    <= '0;
				end else begin
					pixel_row_q <= pixel_row_q + ROW_W'(1);
					if (row_wrap) begin
						row_in_blk_q <= '0;
						blk_row_q    <= blk_row_q + ROW_W'(1);
					end else begin
						row_in_blk_q <= row_in_blk_q + BLK_W'(1);
					end
				end
			end else begin
				pixel_col_q <= pixel_col_q + COL_W'(1);
				if (col_wrap) begin
					col_in_blk_q <= '0;
					blk_col_q    <= blk_col_q + COL_W'(1);
				end else begin
					col_in_blk_q <= col_in_blk_q + BLK_W'(1);
				end
			end
		end
	end

`ifndef ASSERT_OFF
	// Counters never run past the configured frame or block
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		WIDTH_W'(pixel_col_q) < width_q)
		else $error("pixel column beyond image width");
	a_col_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		SIDE_W'(col_in_blk_q) < side_q && SIDE_W'(row_in_blk_q) < side_q)
		else $error("position in block beyond block side");
`endif

endmodule

// File: rtl/bap_accum.sv
`timescale 1ns / 1ps

module bap_accum import bap_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  rgb_t    pix,
	input  scan_t   ctl,
	output logic    valid_s1,
	output logic    push,
	output result_t res
);

	localparam int SW = $bits(sums_t);

	logic [SW-1:0]    rd_data;
	rgb_t             pix_s1;
	scan_t            ctl_s1;
	logic             fwd_s1;
	sums_t            fwd_data_s1;
	sums_t            base;
	sums_t            sum_new;
	logic [SUM_W-1:0] thr;

	// Column sums, one entry per block column
	bap_ram #(
		.DEPTH(MAX_WIDTH),
		.WIDTH(SW)
	) u_sum_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (ctl.addr),
		.rd_data (rd_data),
		.wr_en   (valid_s1),
		.wr_addr (ctl_s1.addr),
		.wr_data (sum_new)
	);

	// Stage 1 control; forward when this read raced the previous write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			fwd_s1   <= accept && valid_s1 && (ctl.addr == ctl_s1.addr);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pix;
			ctl_s1      <= ctl;
			fwd_data_s1 <= sum_new;
		end
	end

	// Read-modify-write: first pixel of a block overwrites the entry
	always_comb begin
		if (ctl_s1.first) begin
			base = '0;
		end else if (fwd_s1) begin
			base = fwd_data_s1;
		end else begin
			base = sums_t'(rd_data);
		end
		sum_new.r = base.r + SUM_W'(pix_s1.r);
		sum_new.g = base.g + SUM_W'(pix_s1.g);
		sum_new.b = base.b + SUM_W'(pix_s1.b);
	end

	// Quantize against 128 * pixel count
	assign thr  = SUM_W'(ctl_s1.count) << THR_SHIFT;
	assign push = valid_s1 && ctl_s1.block_end;

	always_comb begin
		res.block_x    = ctl_s1.block_x;
		res.block_y    = ctl_s1.block_y;
		res.red        = (sum_new.r >= thr) ? QUANT_HIGH : QUANT_LOW;
		res.green      = (sum_new.g >= thr) ? QUANT_HIGH : QUANT_LOW;
		res.blue       = (sum_new.b >= thr) ? QUANT_HIGH : QUANT_LOW;
		res.frame_done = ctl_s1.frame_done;
	end

`ifndef ASSERT_OFF
	// Forwarding only follows a write-back in the cycle before
	a_fwd_follows_write: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1 && $past(valid_s1))
		else $error("forwarded sum without a preceding write-back");
`endif

endmodule

// File: rtl/bap_out_fifo.sv
`timescale 1ns / 1ps

module bap_out_fifo import bap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  result_t          din,
	bap_blk_if.source        blk,
	output logic [LVL_W-1:0] level
);

	result_t          mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             pop;
	result_t          head;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(OUT_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	assign head          = mem_q[rd_ptr_q];
	assign blk.valid     = level_q != '0;
	assign blk.block_x   = head.block_x;
	assign blk.block_y   = head.block_y;
	assign blk.red_out   = head.red;
	assign blk.green_out = head.green;
	assign blk.blue_out  = head.blue;
	assign blk.frame_done = head.frame_done;
	assign pop           = blk.valid && blk.ready;
	assign level         = level_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			level_q <= level_q + LVL_W'(push) - LVL_W'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level_q < LVL_W'(OUT_DEPTH)) || pop)
		else $error("result pushed into full queue");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(OUT_DEPTH))
		else $error("queue level out of range");
`endif

endmodule

// File: rtl/block_average_pixelate_core.sv
`timescale 1ns / 1ps

// Block-average pixelate core. Takes one RGB pixel per clock in raster order
// and, on the bottom-right pixel of each block (edge blocks clipped), returns
// the block coordinates with each channel quantized to 192 or 64 against the
// block's floor average of 128. Sustained rate is one pixel per cycle while the
// output keeps up; a block result goes through stage 1 into the output queue.
// The rate is set by the read-modify-write of the column sum memory, one read
// and one write per cycle, with the write-back forwarded to a pixel of the
// same block column that follows directly. No clearing pass is needed after
// reset: the first pixel of each block overwrites its column entry. A three
// entry output queue lets pixels keep flowing while a result waits; the input
// stalls once the queued results plus the pixel in the pipeline stage reach
// the queue depth of three. The configuration port is
// always ready; writing any of its registers restarts the frame at the
// top-left pixel, and should happen only while the core is idle.
module block_average_pixelate_core import bap_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bap_pix_if.sink    pixels,
	bap_blk_if.source  blocks,
	bap_cfg_if.sink    cfg
);

	scan_t            ctl;
	rgb_t             pix;
	result_t          res;
	logic             accept;
	logic             valid_s1;
	logic             push;
	logic [LVL_W-1:0] level;
	logic [LVL_W:0]   occupied;

	// Input handshake: space for every item already in flight
	assign occupied     = (LVL_W + 1)'(level) + (LVL_W + 1)'(valid_s1);
	assign pixels.ready = occupied < (LVL_W + 1)'(OUT_DEPTH);
	assign accept       = pixels.valid && pixels.ready;

	assign pix.r = pixels.red_in;
	assign pix.g = pixels.green_in;
	assign pix.b = pixels.blue_in;

	bap_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.ctl    (ctl)
	);

	bap_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.pix      (pix),
		.ctl      (ctl),
		.valid_s1 (valid_s1),
		.push     (push),
		.res      (res)
	);

	bap_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res),
		.blk    (blocks),
		.level  (level)
	);

endmodule
